// ===== hdl/mips_integer_execute_unit_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the execute unit RTL.
// ---------------------------------------------------------------------------
`ifndef MIPS_INTEGER_EXECUTE_UNIT_TOP_DEFINES_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define MIE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/mie_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mie_pkg
// Opcodes, trap codes and interface types of the MIPS32 execute unit.
// ---------------------------------------------------------------------------
package mie_pkg;

   localparam int REG_COUNT = 32;

   localparam logic [5:0] OP_ADD   = 6'd0;
   localparam logic [5:0] OP_ADDU  = 6'd1;
   localparam logic [5:0] OP_AND   = 6'd2;
   localparam logic [5:0] OP_DIV   = 6'd3;
   localparam logic [5:0] OP_DIVU  = 6'd4;
   localparam logic [5:0] OP_JR    = 6'd5;
   localparam logic [5:0] OP_MFHI  = 6'd6;
   localparam logic [5:0] OP_MFLO  = 6'd7;
   localparam logic [5:0] OP_MTHI  = 6'd8;
   localparam logic [5:0] OP_MTLO  = 6'd9;
   localparam logic [5:0] OP_MULT  = 6'd10;
   localparam logic [5:0] OP_MULTU = 6'd11;
   localparam logic [5:0] OP_NOR   = 6'd12;
   localparam logic [5:0] OP_OR    = 6'd13;
   localparam logic [5:0] OP_SLL   = 6'd14;
   localparam logic [5:0] OP_SLT   = 6'd15;
   localparam logic [5:0] OP_SLTU  = 6'd16;
   localparam logic [5:0] OP_SRL   = 6'd17;
   localparam logic [5:0] OP_SUB   = 6'd18;
   localparam logic [5:0] OP_SUBU  = 6'd19;
   localparam logic [5:0] OP_XOR   = 6'd20;
   localparam logic [5:0] OP_ADDI  = 6'd21;
   localparam logic [5:0] OP_ADDIU = 6'd22;
   localparam logic [5:0] OP_ANDI  = 6'd23;
   localparam logic [5:0] OP_BEQ   = 6'd24;
   localparam logic [5:0] OP_BGEZ  = 6'd25;
   localparam logic [5:0] OP_BGTZ  = 6'd26;
   localparam logic [5:0] OP_BLEZ  = 6'd27;
   localparam logic [5:0] OP_BLTZ  = 6'd28;
   localparam logic [5:0] OP_BNE   = 6'd29;
   localparam logic [5:0] OP_LUI   = 6'd30;
   localparam logic [5:0] OP_ORI   = 6'd31;
   localparam logic [5:0] OP_SLTI  = 6'd32;
   localparam logic [5:0] OP_SLTIU = 6'd33;
   localparam logic [5:0] OP_XORI  = 6'd34;
   localparam logic [5:0] OP_J     = 6'd35;
   localparam logic [5:0] OP_JAL   = 6'd36;

   localparam logic [1:0] TRAP_NONE     = 2'd0;
   localparam logic [1:0] TRAP_OVERFLOW = 2'd1;
   localparam logic [1:0] TRAP_DIVIDE   = 2'd2;

   localparam logic [4:0] LINK_REG = 5'd31;

   // Start request to the multiply/divide unit.
   typedef struct packed {
      logic        go;
      logic        is_div;
      logic        is_signed;
      logic [31:0] a;
      logic [31:0] b;
   } md_req_type;

   // Completion from the multiply/divide unit.
   typedef struct packed {
      logic        done;
      logic [31:0] hi;
      logic [31:0] lo;
   } md_rsp_type;

   // Decoded outcome of one instruction.
   typedef struct packed {
      logic [1:0]  trap;
      logic        wr;
      logic [4:0]  widx;
      logic [31:0] wval;
      logic        jump;
      logic [31:0] target;
      logic        set_hi;
      logic        set_lo;
      logic        md_go;
      logic        md_div;
      logic        md_signed;
   } exec_type;

endpackage

// ===== hdl/mie_muldiv.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mie_muldiv
// Iterative shift-add multiplier and restoring divider on one shared adder.
// ---------------------------------------------------------------------------
module mie_muldiv (
   input  logic               clock,
   input  logic               reset,
   input  mie_pkg::md_req_type md_req,
   output mie_pkg::md_rsp_type md_rsp
);
   import mie_pkg::*;

   localparam logic [1:0] MD_IDLE = 2'd0;
   localparam logic [1:0] MD_STEP = 2'd1;
   localparam logic [1:0] MD_FIX  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic        div_ff, div_in;
   logic        neg_lo_ff, neg_lo_in;
   logic        neg_hi_ff, neg_hi_in;
   logic [31:0] opnd_ff, opnd_in;
   logic [32:0] hi_ff, hi_in;
   logic [31:0] lo_ff, lo_in;

   logic        na, nb, sub;
   logic [31:0] ma, mb;
   logic [32:0] add_x, add_y;
   logic [33:0] add_s;
   logic [63:0] prod_neg;

   assign na = md_req.is_signed & md_req.a[31];
   assign nb = md_req.is_signed & md_req.b[31];
   assign ma = na ? (32'd0 - md_req.a) : md_req.a;
   assign mb = nb ? (32'd0 - md_req.b) : md_req.b;

   // The single adder: accumulate for multiply, trial subtract for divide.
   always_comb begin
      sub = div_ff;
      if (div_ff) begin
         add_x = {hi_ff[31:0], lo_ff[31]};
         add_y = {1'b0, opnd_ff};
      end else begin
         add_x = {1'b0, hi_ff[31:0]};
         add_y = lo_ff[0] ? {1'b0, opnd_ff} : 33'd0;
      end
      add_s = {1'b0, add_x} + {1'b0, add_y ^ {33{sub}}} + {33'd0, sub};
   end

   assign prod_neg = 64'd0 - {hi_ff[31:0], lo_ff};

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      div_in    = div_ff;
      neg_lo_in = neg_lo_ff;
      neg_hi_in = neg_hi_ff;
      opnd_in   = opnd_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      unique case (state_ff)
         MD_IDLE: begin
            if (md_req.go) begin
               state_in  = MD_STEP;
               cnt_in    = 5'd0;
               div_in    = md_req.is_div;
               hi_in     = 33'd0;
               neg_lo_in = na ^ nb;
               neg_hi_in = md_req.is_div ? na : (na ^ nb);
               opnd_in   = md_req.is_div ? mb : ma;
               lo_in     = md_req.is_div ? ma : mb;
            end
         end
         MD_STEP: begin
            if (div_ff) begin
               hi_in = add_s[33] ? add_s[32:0] : add_x;
               lo_in = {lo_ff[30:0], add_s[33]};
            end else begin
               hi_in = {1'b0, add_s[32:1]};
               lo_in = {add_s[0], lo_ff[31:1]};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = MD_FIX;
            end
         end
         MD_FIX: begin
            if (div_ff) begin
               lo_in = neg_lo_ff ? (32'd0 - lo_ff) : lo_ff;
               hi_in = {1'b0, neg_hi_ff ? (32'd0 - hi_ff[31:0]) : hi_ff[31:0]};
            end else if (neg_lo_ff) begin
               hi_in = {1'b0, prod_neg[63:32]};
               lo_in = prod_neg[31:0];
            end
            done_in  = 1'b1;
            state_in = MD_IDLE;
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      div_ff    <= div_in;
      neg_lo_ff <= neg_lo_in;
      neg_hi_ff <= neg_hi_in;
      opnd_ff   <= opnd_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.hi   = hi_ff[31:0];
   assign md_rsp.lo   = lo_ff;

endmodule

// ===== hdl/mie_alu.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mie_alu
// Decodes one instruction and computes its outcome combinationally.
// ---------------------------------------------------------------------------
module mie_alu (
   input  logic [5:0]       opcode,
   input  logic [4:0]       dest_reg,
   input  logic [4:0]       src_b_reg,
   input  logic [4:0]       shift_amount,
   input  logic [15:0]      imm_value,
   input  logic [25:0]      jump_target,
   input  logic [31:0]      a,
   input  logic [31:0]      b,
   input  logic [31:0]      hi,
   input  logic [31:0]      lo,
   input  logic [31:0]      pc_plus1,
   output mie_pkg::exec_type res
);
   import mie_pkg::*;

   logic [31:0] si, zi, sum_ab, dif_ab, sum_ai;

   assign si     = {{16{imm_value[15]}}, imm_value};
   assign zi     = {16'd0, imm_value};
   assign sum_ab = a + b;
   assign dif_ab = a - b;
   assign sum_ai = a + si;

   always_comb begin
      res           = '0;
      res.target    = zi;
      res.md_signed = (opcode == OP_DIV) || (opcode == OP_MULT);
      unique case (opcode)
         OP_ADD: begin
            if (((a ^ sum_ab) & (b ^ sum_ab)) >> 31 != 32'd0) begin
               res.trap = TRAP_OVERFLOW;
            end else begin
               res.wr = 1'b1; res.widx = dest_reg; res.wval = sum_ab;
            end
         end
         OP_ADDU:  begin res.wr = 1'b1; res.widx = dest_reg; res.wval = sum_ab; end
         OP_AND:   begin res.wr = 1'b1; res.widx = dest_reg; res.wval = a & b; end
         OP_DIV: begin
            if (b == 32'd0 || (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)) begin
               res.trap = TRAP_DIVIDE;
            end else begin
               res.md_go = 1'b1; res.md_div = 1'b1;
            end
         end
         OP_DIVU: begin
            if (b == 32'd0) begin
               res.trap = TRAP_DIVIDE;
            end else begin
               res.md_go = 1'b1; res.md_div = 1'b1;
            end
         end
         OP_JR:    begin res.jump = 1'b1; res.target = a; end
         OP_MFHI:  begin res.wr = 1'b1; res.widx = dest_reg; res.wval = hi; end
         OP_MFLO:  begin res.wr = 1'b1; res.widx = dest_reg; res.wval = lo; end
         OP_MTHI:  res.set_hi = 1'b1;
         OP_MTLO:  res.set_lo = 1'b1;
         OP_MULT, OP_MULTU: res.md_go = 1'b1;
         OP_NOR:   begin res.wr = 1'b1; res.widx = dest_reg; res.wval = ~(a | b); end
         OP_OR:    begin res.wr = 1'b1; res.widx = dest_reg; res.wval = a | b; end
         OP_SLL:   begin res.wr = 1'b1; res.widx = dest_reg; res.wval = b << shift_amount; end
         OP_SLT: begin
            res.wr = 1'b1; res.widx = dest_reg;
            res.wval = {31'd0, $signed(a) < $signed(b)};
         end
         OP_SLTU:  begin res.wr = 1'b1; res.widx = dest_reg; res.wval = {31'd0, a < b}; end
         OP_SRL:   begin res.wr = 1'b1; res.widx = dest_reg; res.wval = b >> shift_amount; end
         OP_SUB: begin
            if (((a ^ b) & (a ^ dif_ab)) >> 31 != 32'd0) begin
               res.trap = TRAP_OVERFLOW;
            end else begin
               res.wr = 1'b1; res.widx = dest_reg; res.wval = dif_ab;
            end
         end
         OP_SUBU:  begin res.wr = 1'b1; res.widx = dest_reg; res.wval = dif_ab; end
         OP_XOR:   begin res.wr = 1'b1; res.widx = dest_reg; res.wval = a ^ b; end
         OP_ADDI: begin
            if (((a ^ sum_ai) & (si ^ sum_ai)) >> 31 != 32'd0) begin
               res.trap = TRAP_OVERFLOW;
            end else begin
               res.wr = 1'b1; res.widx = src_b_reg; res.wval = sum_ai;
            end
         end
         OP_ADDIU: begin res.wr = 1'b1; res.widx = src_b_reg; res.wval = sum_ai; end
         OP_ANDI:  begin res.wr = 1'b1; res.widx = src_b_reg; res.wval = a & zi; end
         OP_BEQ:   res.jump = (a == b);
         OP_BGEZ:  res.jump = !a[31];
         OP_BGTZ:  res.jump = !a[31] && (a != 32'd0);
         OP_BLEZ:  res.jump = a[31] || (a == 32'd0);
         OP_BLTZ:  res.jump = a[31];
         OP_BNE:   res.jump = (a != b);
         OP_LUI:   begin res.wr = 1'b1; res.widx = src_b_reg; res.wval = zi << 16; end
         OP_ORI:   begin res.wr = 1'b1; res.widx = src_b_reg; res.wval = a | zi; end
         OP_SLTI: begin
            res.wr = 1'b1; res.widx = src_b_reg;
            res.wval = {31'd0, $signed(a) < $signed(si)};
         end
         OP_SLTIU: begin res.wr = 1'b1; res.widx = src_b_reg; res.wval = {31'd0, a < si}; end
         OP_XORI:  begin res.wr = 1'b1; res.widx = src_b_reg; res.wval = a ^ zi; end
         OP_J:     begin res.jump = 1'b1; res.target = {6'd0, jump_target}; end
         OP_JAL: begin
            res.jump = 1'b1; res.target = {6'd0, jump_target};
            res.wr = 1'b1; res.widx = LINK_REG; res.wval = pc_plus1;
         end
         default: begin
            res.target = zi;
         end
      endcase
   end

endmodule

// ===== hdl/mips_integer_execute_unit_top.sv =====
`timescale 1ns / 1ps
// Each request passes through the execute state to the response state; mult,
// multu, div and divu wait between the two for the shared unit (32 steps and
// a sign fix-up, then a registered done). One request is in flight at a time,
// so a new request is taken only once the previous response has been taken.
// Synchronous reset clears the registers, HI, LO and the pc.
// ---------------------------------------------------------------------------
// mips_integer_execute_unit_top
// Executes one decoded MIPS32 integer instruction per request against the
// register file, HI, LO and the instruction-index program counter.
// ---------------------------------------------------------------------------
`include "mips_integer_execute_unit_top_defines.svh"
module mips_integer_execute_unit_top #(
   parameter int PC_BITS = 26
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [5:0]         req_opcode,
   input  logic [4:0]         req_dest_reg,
   input  logic [4:0]         req_src_a_reg,
   input  logic [4:0]         req_src_b_reg,
   input  logic [4:0]         req_shift_amount,
   input  logic [15:0]        req_imm_value,
   input  logic [25:0]        req_jump_target,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PC_BITS-1:0] rsp_next_pc,
   output logic [1:0]         rsp_trap_code,
   output logic               rsp_reg_written,
   output logic [4:0]         rsp_written_index,
   output logic [31:0]        rsp_written_value
);
   import mie_pkg::*;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_MDWT = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0]  state_ff, state_in;

   // The captured request.
   logic [5:0]  op_ff;
   logic [4:0]  rd_ff, rt_ff, sa_ff;
   logic [15:0] imm_ff;
   logic [25:0] tgt_ff;

   // Register file: a memory with a valid bit per entry so that reset reads
   // as zero at once. Entry zero is never written and so always reads zero.
   logic [31:0] rf_mem [REG_COUNT];
   logic [REG_COUNT-1:0] rf_vld_ff;
   logic [31:0] rd_a_ff, rd_b_ff;
   logic        vld_a_ff, vld_b_ff;
   logic [31:0] a, b;

   logic [31:0] hi_ff, lo_ff;
   logic [PC_BITS-1:0] pc_ff, pc_plus1;

   logic [PC_BITS-1:0] rsp_pc_ff, rsp_pc_in;
   logic [1:0]  rsp_trap_ff, rsp_trap_in;
   logic        rsp_wr_ff, rsp_wr_in;
   logic [4:0]  rsp_idx_ff, rsp_idx_in;
   logic [31:0] rsp_val_ff, rsp_val_in;

   logic        accept, exec_commit, wr_eff;
   exec_type    ex;
   md_req_type  md_req;
   md_rsp_type  md_rsp;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign pc_plus1  = PC_BITS'(pc_ff + 1'b1);

   assign a = vld_a_ff ? rd_a_ff : 32'd0;
   assign b = vld_b_ff ? rd_b_ff : 32'd0;

   mie_alu u_alu (
      .opcode       (op_ff),
      .dest_reg     (rd_ff),
      .src_b_reg    (rt_ff),
      .shift_amount (sa_ff),
      .imm_value    (imm_ff),
      .jump_target  (tgt_ff),
      .a            (a),
      .b            (b),
      .hi           (hi_ff),
      .lo           (lo_ff),
      .pc_plus1     (32'(pc_plus1)),
      .res          (ex)
   );

   assign md_req.go        = (state_ff == ST_EXEC) && ex.md_go;
   assign md_req.is_div    = ex.md_div;
   assign md_req.is_signed = ex.md_signed;
   assign md_req.a         = a;
   assign md_req.b         = b;

   mie_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   // An instruction that does not use the multiply/divide unit commits in the
   // execute state; a trap commits nothing and leaves the pc where it was.
   assign exec_commit = (state_ff == ST_EXEC) && !ex.md_go;
   assign wr_eff      = (ex.trap == TRAP_NONE) && ex.wr && (ex.widx != 5'd0);

   always_comb begin
      state_in    = state_ff;
      rsp_pc_in   = rsp_pc_ff;
      rsp_trap_in = rsp_trap_ff;
      rsp_wr_in   = rsp_wr_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_val_in  = rsp_val_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (ex.md_go) begin
               state_in = ST_MDWT;
            end else begin
               state_in    = ST_RESP;
               rsp_trap_in = ex.trap;
               rsp_wr_in   = wr_eff;
               rsp_idx_in  = wr_eff ? ex.widx : 5'd0;
               rsp_val_in  = wr_eff ? ex.wval : 32'd0;
               if (ex.trap != TRAP_NONE) begin
                  rsp_pc_in = pc_ff;
               end else if (ex.jump) begin
                  rsp_pc_in = ex.target[PC_BITS-1:0];
               end else begin
                  rsp_pc_in = pc_plus1;
               end
            end
         end
         ST_MDWT: begin
            if (md_rsp.done) begin
               state_in    = ST_RESP;
               rsp_pc_in   = pc_plus1;
               rsp_trap_in = TRAP_NONE;
               rsp_wr_in   = 1'b0;
               rsp_idx_in  = 5'd0;
               rsp_val_in  = 32'd0;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rf_vld_ff <= '0;
         hi_ff     <= 32'd0;
         lo_ff     <= 32'd0;
         pc_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (exec_commit) begin
            if (wr_eff) begin
               rf_vld_ff[ex.widx] <= 1'b1;
            end
            if (ex.trap == TRAP_NONE) begin
               if (ex.set_hi) begin
                  hi_ff <= a;
               end
               if (ex.set_lo) begin
                  lo_ff <= a;
               end
            end
            pc_ff <= rsp_pc_in;
         end else if (state_ff == ST_MDWT && md_rsp.done) begin
            hi_ff <= md_rsp.hi;
            lo_ff <= md_rsp.lo;
            pc_ff <= pc_plus1;
         end
      end
   end

   // Register file write and registered reads.
   always_ff @(posedge clock) begin
      if (exec_commit && wr_eff) begin
         rf_mem[ex.widx] <= ex.wval;
      end
      if (accept) begin
         rd_a_ff  <= rf_mem[req_src_a_reg];
         rd_b_ff  <= rf_mem[req_src_b_reg];
         vld_a_ff <= rf_vld_ff[req_src_a_reg];
         vld_b_ff <= rf_vld_ff[req_src_b_reg];
         op_ff    <= req_opcode;
         rd_ff    <= req_dest_reg;
         rt_ff    <= req_src_b_reg;
         sa_ff    <= req_shift_amount;
         imm_ff   <= req_imm_value;
         tgt_ff   <= req_jump_target;
      end
      rsp_pc_ff   <= rsp_pc_in;
      rsp_trap_ff <= rsp_trap_in;
      rsp_wr_ff   <= rsp_wr_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_val_ff  <= rsp_val_in;
   end

   assign rsp_next_pc       = rsp_pc_ff;
   assign rsp_trap_code     = rsp_trap_ff;
   assign rsp_reg_written   = rsp_wr_ff;
   assign rsp_written_index = rsp_idx_ff;
   assign rsp_written_value = rsp_val_ff;

   // Register zero must never be marked as written.
   `MIE_ASSERT_NOW(a_zero_invalid, clock, reset, 1'b1, !rf_vld_ff[0], "register zero written")
   // A trapped response reports no register write.
   `MIE_ASSERT_NOW(a_trap_no_write, clock, reset, rsp_valid && (rsp_trap_code != TRAP_NONE), !rsp_reg_written, "trap with write")
   // An accepted request always moves on to the execute state.
   `MIE_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == ST_EXEC, "accept lost")
   // The shared unit only finishes while the sequencer waits for it.
   `MIE_ASSERT_NOW(a_done_in_wait, clock, reset, md_rsp.done, state_ff == ST_MDWT, "stray unit completion")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MIPS32 integer execute unit testbench
// Drives decoded instructions into the execute unit, keeps its own copy of
// the register file, HI, LO and the pc, and checks every response field by
// field against the predicted outcome, with random idling on both sides.
// ---------------------------------------------------------------------------
module testbench;
   import mie_pkg::*;

   typedef struct {
      logic [5:0]  opcode;
      logic [4:0]  rd;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  sa;
      logic [15:0] imm;
      logic [25:0] target;
   } instr_type;

   typedef struct {
      logic [25:0] next_pc;
      logic [1:0]  trap;
      logic        wr;
      logic [4:0]  widx;
      logic [31:0] wval;
   } outcome_type;

   // Architectural shadow of the unit and the queue of outcomes still owed.
   class exec_scoreboard;
      logic [31:0] gpr [32];
      logic [31:0] hi;
      logic [31:0] lo;
      logic [25:0] pc;
      outcome_type owed_q[$];
      int          failures;

      function new();
         foreach (gpr[i]) gpr[i] = '0;
         hi = '0;
         lo = '0;
         pc = '0;
         failures = 0;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      // Executes one accepted request on the shadow state and queues its outcome.
      function void note_request(instr_type r);
         logic [31:0] a, b, si, zi, t, new_hi, new_lo;
         logic [63:0] p;
         logic signed [31:0] sa_v, sb_v;
         logic [25:0] npc;
         logic [25:0] bt;
         outcome_type o;
         a = gpr[r.rs];
         b = gpr[r.rt];
         si = {{16{r.imm[15]}}, r.imm};
         zi = {16'h0, r.imm};
         bt = {10'd0, r.imm};
         sa_v = a;
         sb_v = b;
         npc = pc + 26'd1;
         new_hi = hi;
         new_lo = lo;
         o.trap = TRAP_NONE;
         o.wr = 1'b0;
         o.widx = r.rd;
         o.wval = '0;
         case (r.opcode)
            OP_ADD: begin
               t = a + b;
               if (a[31] == b[31] && t[31] != a[31]) o.trap = TRAP_OVERFLOW;
               else begin o.wr = 1'b1; o.wval = t; end
            end
            OP_ADDU: begin o.wr = 1'b1; o.wval = a + b; end
            OP_AND:  begin o.wr = 1'b1; o.wval = a & b; end
            OP_DIV: begin
               if (b == 0 || (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)) o.trap = TRAP_DIVIDE;
               else begin new_lo = sa_v / sb_v; new_hi = sa_v % sb_v; end
            end
            OP_DIVU: begin
               if (b == 0) o.trap = TRAP_DIVIDE;
               else begin new_lo = a / b; new_hi = a % b; end
            end
            OP_JR:   npc = a[25:0];
            OP_MFHI: begin o.wr = 1'b1; o.wval = hi; end
            OP_MFLO: begin o.wr = 1'b1; o.wval = lo; end
            OP_MTHI: new_hi = a;
            OP_MTLO: new_lo = a;
            OP_MULT: begin
               p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
               new_hi = p[63:32];
               new_lo = p[31:0];
            end
            OP_MULTU: begin
               p = {32'h0, a} * {32'h0, b};
               new_hi = p[63:32];
               new_lo = p[31:0];
            end
            OP_NOR:  begin o.wr = 1'b1; o.wval = ~(a | b); end
            OP_OR:   begin o.wr = 1'b1; o.wval = a | b; end
            OP_SLL:  begin o.wr = 1'b1; o.wval = b << r.sa; end
            OP_SLT:  begin o.wr = 1'b1; o.wval = (sa_v < sb_v) ? 32'd1 : 32'd0; end
            OP_SLTU: begin o.wr = 1'b1; o.wval = (a < b) ? 32'd1 : 32'd0; end
            OP_SRL:  begin o.wr = 1'b1; o.wval = b >> r.sa; end
            OP_SUB: begin
               t = a - b;
               if (a[31] != b[31] && t[31] != a[31]) o.trap = TRAP_OVERFLOW;
               else begin o.wr = 1'b1; o.wval = t; end
            end
            OP_SUBU: begin o.wr = 1'b1; o.wval = a - b; end
            OP_XOR:  begin o.wr = 1'b1; o.wval = a ^ b; end
            OP_ADDI: begin
               t = a + si;
               o.widx = r.rt;
               if (a[31] == si[31] && t[31] != a[31]) o.trap = TRAP_OVERFLOW;
               else begin o.wr = 1'b1; o.wval = t; end
            end
            OP_ADDIU: begin o.wr = 1'b1; o.widx = r.rt; o.wval = a + si; end
            OP_ANDI:  begin o.wr = 1'b1; o.widx = r.rt; o.wval = a & zi; end
            OP_BEQ:   if (a == b) npc = bt;
            OP_BGEZ:  if (!a[31]) npc = bt;
            OP_BGTZ:  if (!a[31] && a != 0) npc = bt;
            OP_BLEZ:  if (a[31] || a == 0) npc = bt;
            OP_BLTZ:  if (a[31]) npc = bt;
            OP_BNE:   if (a != b) npc = bt;
            OP_LUI:   begin o.wr = 1'b1; o.widx = r.rt; o.wval = {r.imm, 16'h0}; end
            OP_ORI:   begin o.wr = 1'b1; o.widx = r.rt; o.wval = a | zi; end
            OP_SLTI: begin
               o.wr = 1'b1;
               o.widx = r.rt;
               o.wval = (sa_v < $signed(si)) ? 32'd1 : 32'd0;
            end
            OP_SLTIU: begin o.wr = 1'b1; o.widx = r.rt; o.wval = (a < si) ? 32'd1 : 32'd0; end
            OP_XORI:  begin o.wr = 1'b1; o.widx = r.rt; o.wval = a ^ zi; end
            OP_J:     npc = r.target;
            OP_JAL: begin
               o.wr = 1'b1;
               o.widx = LINK_REG;
               o.wval = {6'h0, pc + 26'd1};
               npc = r.target;
            end
            default: ;
         endcase
         if (o.trap != TRAP_NONE) begin
            npc = pc;
            o.wr = 1'b0;
         end else begin
            hi = new_hi;
            lo = new_lo;
            pc = npc;
         end
         if (!o.wr || o.widx == 0) begin
            o.wr = 1'b0;
            o.widx = '0;
            o.wval = '0;
         end else begin
            gpr[o.widx] = o.wval;
         end
         o.next_pc = npc;
         owed_q.push_back(o);
      endfunction

      function void check_response(outcome_type got);
         outcome_type want;
         if (owed_q.size() == 0) begin
            $error("response with nothing outstanding: next_pc %h", got.next_pc);
            failures++;
            return;
         end
         want = owed_q.pop_front();
         if (got.next_pc !== want.next_pc) begin
            $error("next_pc: expected %h, actual %h", want.next_pc, got.next_pc);
            failures++;
         end
         if (got.trap !== want.trap) begin
            $error("trap_code: expected %0d, actual %0d", want.trap, got.trap);
            failures++;
         end
         if (got.wr !== want.wr) begin
            $error("reg_written: expected %b, actual %b", want.wr, got.wr);
            failures++;
         end
         if (got.widx !== want.widx) begin
            $error("written_index: expected %0d, actual %0d", want.widx, got.widx);
            failures++;
         end
         if (got.wval !== want.wval) begin
            $error("written_value: expected %h, actual %h", want.wval, got.wval);
            failures++;
         end
      endfunction
   endclass

   localparam int RANDOM_REQUESTS = 1650;
   // The receiver holds off for this long once, so that the unit fills up.
   localparam int HOLD_OFF_AT     = 400;
   localparam int HOLD_OFF_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [5:0]  req_opcode = '0;
   logic [4:0]  req_dest_reg = '0;
   logic [4:0]  req_src_a_reg = '0;
   logic [4:0]  req_src_b_reg = '0;
   logic [4:0]  req_shift_amount = '0;
   logic [15:0] req_imm_value = '0;
   logic [25:0] req_jump_target = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [25:0] rsp_next_pc;
   logic [1:0]  rsp_trap_code;
   logic        rsp_reg_written;
   logic [4:0]  rsp_written_index;
   logic [31:0] rsp_written_value;

   exec_scoreboard sb = new();
   int requests_sent = 0;

   mips_integer_execute_unit_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_dest_reg      (req_dest_reg),
      .req_src_a_reg     (req_src_a_reg),
      .req_src_b_reg     (req_src_b_reg),
      .req_shift_amount  (req_shift_amount),
      .req_imm_value     (req_imm_value),
      .req_jump_target   (req_jump_target),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_trap_code     (rsp_trap_code),
      .rsp_reg_written   (rsp_reg_written),
      .rsp_written_index (rsp_written_index),
      .rsp_written_value (rsp_written_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic instr_type mk(logic [5:0] op, logic [4:0] rd, logic [4:0] rs,
                                    logic [4:0] rt, logic [4:0] sa, logic [15:0] imm,
                                    logic [25:0] tgt);
      instr_type r;
      r.opcode = op;
      r.rd = rd;
      r.rs = rs;
      r.rt = rt;
      r.sa = sa;
      r.imm = imm;
      r.target = tgt;
      return r;
   endfunction

   // Register indices lean towards a small set, so that results feed later
   // requests instead of landing in registers that are never read again.
   function automatic logic [4:0] pick_reg();
      return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
   endfunction

   // Immediates lean towards the sign boundaries, where the traps live.
   function automatic logic [15:0] pick_imm();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offers one request after a random gap and holds it until it is taken.
   // Every fourth stretch of 150 requests runs with no gaps at all.
   task automatic send_request(instr_type r);
      int gap;
      gap = ((requests_sent / 150) % 4 == 3) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_opcode       <= r.opcode;
      req_dest_reg     <= r.rd;
      req_src_a_reg    <= r.rs;
      req_src_b_reg    <= r.rt;
      req_shift_amount <= r.sa;
      req_imm_value    <= r.imm;
      req_jump_target  <= r.target;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      requests_sent++;
   endtask

   // Stimulus: a directed opening, then random requests.
   initial begin
      instr_type r;
      logic [4:0] reg_x;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Signed extremes: r1 = MIN, r2 = -1, r3 = MAX.
      send_request(mk(OP_LUI,   0, 0, 1, 0, 16'h8000, 0));
      send_request(mk(OP_ADDIU, 0, 0, 2, 0, 16'hFFFF, 0));
      send_request(mk(OP_LUI,   0, 0, 3, 0, 16'h7FFF, 0));
      send_request(mk(OP_ORI,   0, 3, 3, 0, 16'hFFFF, 0));
      // Divide faults: MIN / -1 and both divides by zero.
      send_request(mk(OP_DIV,   0, 1, 2, 0, 0, 0));
      send_request(mk(OP_DIV,   0, 1, 0, 0, 0, 0));
      send_request(mk(OP_DIVU,  0, 2, 0, 0, 0, 0));
      // Signed overflow on add, sub and addi.
      send_request(mk(OP_ADD,   4, 1, 2, 0, 0, 0));
      send_request(mk(OP_SUB,   4, 1, 3, 0, 0, 0));
      send_request(mk(OP_ADDI,  0, 3, 4, 0, 16'h0001, 0));
      // Full products into HI:LO, read back.
      send_request(mk(OP_MULT,  0, 1, 2, 0, 0, 0));
      send_request(mk(OP_MFHI,  5, 0, 0, 0, 0, 0));
      send_request(mk(OP_MULTU, 0, 2, 2, 0, 0, 0));
      send_request(mk(OP_MFLO,  6, 0, 0, 0, 0, 0));
      // Signed division with a negative dividend: remainder keeps its sign.
      send_request(mk(OP_DIV,   0, 2, 3, 0, 0, 0));
      send_request(mk(OP_MFHI,  7, 0, 0, 0, 0, 0));
      // A write to register zero is dropped.
      send_request(mk(OP_ADDU,  0, 1, 3, 0, 0, 0));
      send_request(mk(OP_SLTU,  8, 2, 0, 0, 0, 0));
      send_request(mk(OP_SLT,   9, 2, 0, 0, 0, 0));
      send_request(mk(OP_SLL,  10, 0, 2, 31, 0, 0));
      send_request(mk(OP_SRL,  11, 0, 2, 31, 0, 0));
      // Control flow at the extremes of the pc.
      send_request(mk(OP_JAL,   0, 0, 0, 0, 0, 26'h3FF_FFFF));
      send_request(mk(OP_JAL,   0, 0, 0, 0, 0, 26'h000_0000));
      send_request(mk(OP_JR,    0, 2, 0, 0, 0, 0));
      send_request(mk(OP_BEQ,   0, 0, 0, 0, 16'hFFFF, 0));
      send_request(mk(6'd63,    0, 0, 0, 0, 0, 0));

      while (requests_sent < RANDOM_REQUESTS + 26) begin
         if ($urandom_range(0, 4) == 0) begin
            // Load a full 32-bit constant with the usual lui / ori pair.
            reg_x = pick_reg();
            send_request(mk(OP_LUI, pick_reg(), pick_reg(), reg_x, 5'($urandom),
                            pick_imm(), 26'($urandom)));
            send_request(mk(OP_ORI, pick_reg(), reg_x, reg_x, 5'($urandom),
                            pick_imm(), 26'($urandom)));
         end else begin
            r = mk(($urandom_range(0, 19) == 0) ? 6'($urandom_range(37, 63))
                                                : 6'($urandom_range(0, 36)),
                   pick_reg(), pick_reg(), pick_reg(), 5'($urandom), pick_imm(),
                   26'($urandom));
            send_request(r);
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.failures == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // Response side: random stalls, no stalls at all in every fourth stretch of 200
   // responses, and one long hold-off while the sender keeps offering.
   initial begin
      outcome_type got;
      int gap;
      int seen;
      seen = 0;
      wait (!reset);
      forever begin
         if (seen == HOLD_OFF_AT) gap = HOLD_OFF_CYCLES;
         else if ((seen / 200) % 4 == 3) gap = 0;
         else gap = $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got.next_pc = rsp_next_pc;
         got.trap    = rsp_trap_code;
         got.wr      = rsp_reg_written;
         got.widx    = rsp_written_index;
         got.wval    = rsp_written_value;
         sb.check_response(got);
         seen++;
      end
   end

   // Watchdog: well beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
